// ===== design/l2vn_pkg.sv =====
// ============================================================================
// l2vn_pkg
// Shared types and constants of the L2 vector normalizer.
// ============================================================================
package l2vn_pkg;

   // Element code width, Q1.15.
   localparam int ELEM_W = 16;
   // Squared magnitude: |x| <= 2^(ELEM_W-1), so x^2 <= 2^(2*ELEM_W-2).
   localparam int SQ_W   = 2 * ELEM_W - 1;
   // Bit index of the result search.
   localparam int BIT_W  = $clog2(ELEM_W);

   typedef struct packed {
      logic signed [ELEM_W-1:0] element_value;
      logic                     is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] normalized_value;
      logic                     last_result;
      logic                     zero_norm;
      logic                     overflow;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // input transfer: store element, count it
      logic start_vec;  // sum of squares is final; latch zero flag, rewind index
      logic rd;         // read the stored element at the current index
      logic fetch;      // take sign and squared magnitude, clear the search
      logic square;     // square the next odd candidate 2c-1
      logic mult;       // multiply the candidate square by the sum of squares
      logic compare;    // keep or drop the candidate bit
      logic emit;       // load the result register
      logic finish;     // vector done: clear count, sum and overflow
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;  // squares still on their way into the sum
      logic zero;       // the vector norm is zero
      logic bit_zero;   // the search is at its last bit
      logic last_elem;  // the current index is the last stored element
      logic rsp_busy;   // the result register holds a result not yet taken
   } status_type;

endpackage

// ===== design/l2_vector_normalizer_core.sv =====
// ============================================================================
// l2_vector_normalizer_core
// L2 normalization of one vector of signed Q1.15 elements.
// ============================================================================
// Usage:
// The request channel (req_valid / req_ready / req_payload) carries one vector
// element per transfer; is_last marks the final element. Elements are taken
// one per cycle and stored; at most MAX_LEN are kept, and later ones are
// dropped and flag overflow on every result of that vector.
// After the last element, the block waits for the sum of squares to settle,
// then emits each stored element divided by the L2 norm on the response
// channel (rsp_valid / rsp_ready / rsp_payload), in arrival order, with
// last_result on the final one. Each result is rounded to nearest.
// Each result takes one memory read, one fetch, a 16-step bit-serial search
// (each step squares the candidate, multiplies by the sum of squares and
// compares) and an output register load. A zero-norm vector skips the search.
// No new elements are accepted until the whole vector has gone out.
// The result sits in an output register; the next result is computed while it
// waits, so a stalled receiver only holds the block once that one is ready.
// Reset clears the element count, the sum, the overflow flag and the
// sequencer; the element store itself is not cleared.
// ============================================================================
module l2_vector_normalizer_core
   import l2vn_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   // The sequencer owns the request handshake and decides each transfer.
   l2vn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_is_last (req_payload.is_last),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // The datapath holds the store, the sum and the result register.
   l2vn_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/l2vn_datapath.sv =====
// ============================================================================
// l2vn_datapath
// Element store, sum of squares and the bit-serial search for each result.
// ============================================================================
module l2vn_datapath
   import l2vn_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int SUM_W  = SQ_W + $clog2(MAX_LEN);
   localparam int DSQ_W  = 2 * ELEM_W;
   localparam int PROD_W = DSQ_W + SUM_W;

   // Element store.
   logic [ELEM_W-1:0] mem [MAX_LEN];
   logic [ELEM_W-1:0] rd_data_ff;

   // Vector state.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic              zero_ff;
   logic [IDX_W-1:0]  idx_ff;

   // Load pipeline: element, then its square, then the add.
   logic              ld_v_ff, sq_v_ff;
   logic [ELEM_W-1:0] ld_elem_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [ELEM_W-1:0] ld_mag;
   logic [DSQ_W-1:0]  ld_sq_full;

   // Search state.
   logic              neg_ff;
   logic [SQ_W-1:0]   mag_sq_ff;
   logic [ELEM_W-1:0] m_ff, cand_ff, cand;
   logic              cand_ok_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic [DSQ_W-1:0]  dsq_ff;
   logic [PROD_W-1:0] prod_ff, rhs;
   logic [ELEM_W:0]   d_wide;
   logic [ELEM_W-1:0] rd_mag;
   logic [DSQ_W-1:0]  rd_sq_full;

   // Result register.
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;
   logic [ELEM_W-1:0] result;

   logic              store_ok;

   assign store_ok   = (count_ff < CNT_W'(MAX_LEN));
   assign ld_mag     = ld_elem_ff[ELEM_W-1] ? (~ld_elem_ff + 1'b1) : ld_elem_ff;
   assign ld_sq_full = ld_mag * ld_mag;
   assign rd_mag     = rd_data_ff[ELEM_W-1] ? (~rd_data_ff + 1'b1) : rd_data_ff;
   assign rd_sq_full = rd_mag * rd_mag;

   // Candidate c = m with the current bit set; the test uses d = 2c - 1.
   assign cand   = m_ff | (ELEM_W'(1) << bit_ff);
   assign d_wide = {cand, 1'b0} - 1'b1;
   // Right side (2t)^2 with t = |x| * 2^(ELEM_W-1) equals |x|^2 * 2^(2*ELEM_W).
   assign rhs    = PROD_W'({mag_sq_ff, {DSQ_W{1'b0}}});

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      sum_in   = sum_ff;
      if (sq_v_ff) begin
         sum_in = sum_ff + SUM_W'(sq_ff);
      end
      if (cmd.load) begin
         if (store_ok) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
         sum_in   = '0;
      end
   end

   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         result = ~m_ff + 1'b1;
      end else if (m_ff[ELEM_W-1]) begin
         // Plus one saturates to the largest code.
         result = {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
         result = m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         ld_v_ff      <= 1'b0;
         sq_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         ld_v_ff  <= cmd.load && store_ok;
         sq_v_ff  <= ld_v_ff;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         mem[count_ff[IDX_W-1:0]] <= req_payload.element_value;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      ld_elem_ff <= req_payload.element_value;
      sq_ff      <= ld_sq_full[SQ_W-1:0];
      if (cmd.start_vec) begin
         zero_ff <= (sum_ff == '0);
         idx_ff  <= '0;
      end
      if (cmd.fetch) begin
         neg_ff    <= rd_data_ff[ELEM_W-1];
         mag_sq_ff <= rd_sq_full[SQ_W-1:0];
         m_ff      <= '0;
         bit_ff    <= BIT_W'(ELEM_W - 1);
      end
      if (cmd.square) begin
         cand_ff    <= cand;
         // Once m has reached plus one, no larger candidate is allowed.
         cand_ok_ff <= ~m_ff[ELEM_W-1];
         dsq_ff     <= d_wide[ELEM_W-1:0] * d_wide[ELEM_W-1:0];
      end
      if (cmd.mult) begin
         prod_ff <= dsq_ff * sum_ff;
      end
      if (cmd.compare) begin
         if (cand_ok_ff && (prod_ff <= rhs)) begin
            m_ff <= cand_ff;
         end
         bit_ff <= bit_ff - 1'b1;
      end
      if (cmd.emit) begin
         rsp_ff.normalized_value <= result;
         rsp_ff.last_result      <= status.last_elem;
         rsp_ff.zero_norm        <= zero_ff;
         rsp_ff.overflow         <= ovf_ff;
         idx_ff                  <= idx_ff + 1'b1;
      end
   end

   assign status.pipe_busy = ld_v_ff | sq_v_ff;
   assign status.zero      = zero_ff;
   assign status.bit_zero  = (bit_ff == '0);
   assign status.last_elem = ((CNT_W'(idx_ff) + 1'b1) == count_ff);
   assign status.rsp_busy  = rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/l2vn_ctrl.sv =====
// ============================================================================
// l2vn_ctrl
// Sequencer: loads a vector, then walks the stored elements through the search.
// ============================================================================
module l2vn_ctrl
   import l2vn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_is_last,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_DRAIN = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_SQ    = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_CMP   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       out_free;

   assign out_free = ~status.rsp_busy | rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_is_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.start_vec = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = status.zero ? S_OUT : S_SQ;
         end
         S_SQ: begin
            cmd.square = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mult = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = status.bit_zero ? S_OUT : S_SQ;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (status.last_elem) begin
                  cmd.finish = 1'b1;
                  state_in   = S_LOAD;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench of the L2 vector normalizer core: it sends vectors
// of Q1.15 elements, predicts every normalized element, and checks each
// result transfer against that prediction.
// ============================================================================
module tb;
   import l2vn_pkg::*;

   localparam int VEC_CAP    = 64;       // elements kept per vector
   localparam int PLAN_ITEMS = 230;      // random stimulus stops near here
   localparam int DRAIN      = 200;      // quiet cycles after the last result
   localparam int LIMIT      = 400000;   // watchdog, in clock cycles

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the vector being loaded, and a queue of
   // the normalized elements that the block still owes.
   // -------------------------------------------------------------------------
   class norm_scoreboard;
      logic signed [ELEM_W-1:0] elements [VEC_CAP];
      int                       kept;
      logic [63:0]              square_total;
      logic                     truncated;
      rsp_payload_type          owed [$];
      int                       mismatch_count;
      int                       results_seen;

      function new();
         kept           = 0;
         square_total   = '0;
         truncated      = 1'b0;
         mismatch_count = 0;
         results_seen   = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      task flag_mismatch(input string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatch_count++;
      endtask

      // Rounded x * 2^15 / sqrt(S), found by a search on the largest m with
      // (2m-1)^2 * S <= (2 * |x| * 2^15)^2; the sign is applied afterwards.
      function logic signed [ELEM_W-1:0] scale_by_norm(logic [ELEM_W-1:0] code);
         logic [ELEM_W-1:0] mag16;
         logic [127:0]      two_t, bound, lhs, odd, lo, hi, mid, sum_w;
         mag16 = code[ELEM_W-1] ? (~code + 16'd1) : code;
         two_t = 128'(mag16) << ELEM_W;
         bound = two_t * two_t;
         sum_w = 128'(square_total);
         lo    = '0;
         hi    = 128'd32768;
         while (lo < hi) begin
            mid = lo + (hi - lo + 128'd1) / 128'd2;
            odd = 128'd2 * mid - 128'd1;
            lhs = odd * odd * sum_w;
            if (lhs <= bound) lo = mid;
            else hi = mid - 128'd1;
         end
         if (code[ELEM_W-1]) return ~lo[ELEM_W-1:0] + 16'd1;
         // Exactly +1.0 has no code; it saturates to the largest one.
         if (lo >= 128'd32768) return 16'sd32767;
         return lo[ELEM_W-1:0];
      endfunction

      // Called for every accepted input transfer.
      task note_input(input req_payload_type item);
         logic [ELEM_W-1:0] code, mag16;
         rsp_payload_type   e;
         logic              zero;
         code = item.element_value;
         if (kept < VEC_CAP) begin
            mag16          = code[ELEM_W-1] ? (~code + 16'd1) : code;
            elements[kept] = item.element_value;
            kept++;
            square_total   = square_total + 64'(mag16) * 64'(mag16);
         end else begin
            // Dropped elements do not count toward the norm.
            truncated = 1'b1;
         end
         if (item.is_last) begin
            zero = (square_total == 64'd0);
            for (int i = 0; i < kept; i++) begin
               e.normalized_value = zero ? '0 : scale_by_norm(elements[i]);
               e.last_result      = (i + 1 == kept);
               e.zero_norm        = zero;
               e.overflow         = truncated;
               owed = {owed, e};
            end
            kept         = 0;
            square_total = '0;
            truncated    = 1'b0;
         end
      endtask

      // Called for every accepted result transfer.
      task check_result(input rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (owed.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = owed.pop_front();
            if (got.normalized_value !== want.normalized_value)
               flag_mismatch($sformatf("result %0d normalized_value %0d, expected %0d",
                  results_seen, got.normalized_value, want.normalized_value));
            if (got.last_result !== want.last_result)
               flag_mismatch($sformatf("result %0d last_result %b, expected %b",
                  results_seen, got.last_result, want.last_result));
            if (got.zero_norm !== want.zero_norm)
               flag_mismatch($sformatf("result %0d zero_norm %b, expected %b",
                  results_seen, got.zero_norm, want.zero_norm));
            if (got.overflow !== want.overflow)
               flag_mismatch($sformatf("result %0d overflow %b, expected %b",
                  results_seen, got.overflow, want.overflow));
         end
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   norm_scoreboard board;
   int             items_sent;
   int             vectors_sent;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             cycle_count;

   l2_vector_normalizer_core #(
      .MAX_LEN (VEC_CAP)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // The watchdog ends a run that hangs.
   initial begin : watchdog
      while (cycle_count < LIMIT) @(posedge clock);
      $display("timeout after %0d cycles with %0d results outstanding",
         cycle_count, board.pending());
      $display("l2_vector_normalizer_core test failed");
      $finish;
   end

   // Receiver: ready changes only at the falling edge; the idle rate follows
   // the current phase of the run.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result transfers are sampled at the rising edge, before the block's own
   // registers move, and go straight to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_payload);
   end

   // Draws one element value from a mix of full-range, small, extreme and
   // near-full-scale codes.
   function logic signed [ELEM_W-1:0] pick_element();
      logic signed [ELEM_W-1:0] v;
      case ($urandom_range(9)) inside
         [0:3]: v = 16'($urandom);
         [4:5]: v = 16'($signed($urandom_range(510)) - 255);
         6: begin
            case ($urandom_range(4))
               0:       v = 16'sd32767;
               1:       v = 16'sh8000;
               2:       v = 16'sd1;
               3:       v = -16'sd1;
               default: v = '0;
            endcase
         end
         7:       v = '0;
         default: begin
            v = 16'($urandom_range(32767, 16384));
            if ($urandom_range(1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   // Sends one element. The idle rates step through three phases by the
   // number of transfers so far, so gaps land anywhere in the block's work.
   task send_element(input req_payload_type item);
      if (items_sent < PLAN_ITEMS / 3) begin
         send_idle_pct = 25;
         recv_idle_pct = 85;
      end else if (items_sent < 2 * PLAN_ITEMS / 3) begin
         send_idle_pct = 85;
         recv_idle_pct = 25;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      board.note_input(item);
      items_sent++;
      @(negedge clock);
   endtask

   // Sends a whole vector, with is_last on its final element.
   task send_vector(input logic signed [ELEM_W-1:0] vals [$]);
      req_payload_type item;
      for (int i = 0; i < vals.size(); i++) begin
         item.element_value = vals[i];
         item.is_last       = (i == vals.size() - 1);
         send_element(item);
      end
      vectors_sent++;
   endtask

   initial begin
      logic signed [ELEM_W-1:0] vec [$];
      int                       len;
      int                       vec_index;
      logic                     zero_vec;

      board         = new();
      items_sent    = 0;
      vectors_sent  = 0;
      send_idle_pct = 25;
      recv_idle_pct = 85;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed vectors: single extremes (plus one saturates, minus one is
      // exact), zero-norm vectors, exact small ratios, and zeros in a
      // nonzero vector.
      vec = {16'sd32767};                 send_vector(vec);
      vec = {16'sh8000};                  send_vector(vec);
      vec = {16'sd0};                     send_vector(vec);
      vec = {16'sd1};                     send_vector(vec);
      vec = {-16'sd1};                    send_vector(vec);
      vec = {16'sd0, 16'sd0, 16'sd0};     send_vector(vec);
      vec = {16'sd32767, 16'sh8000};      send_vector(vec);
      vec = {16'sd3, 16'sd4};             send_vector(vec);
      vec = {16'sd0, 16'sd5, 16'sd0};     send_vector(vec);
      vec = {16'sd1, 16'sd32767};         send_vector(vec);
      vec = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_vector(vec);

      // Random vectors, mostly short. One overruns the store so that its
      // last element is dropped yet still closes the vector; one fills the
      // store exactly.
      vec_index = 0;
      while (items_sent < PLAN_ITEMS) begin
         if (vec_index == 2) len = VEC_CAP + 2;
         else if (vec_index == 5) len = VEC_CAP;
         else len = $urandom_range(8, 1);
         zero_vec = ($urandom_range(9) == 0);
         vec = {};
         for (int i = 0; i < len; i++) vec = {vec, (zero_vec ? 16'sd0 : pick_element())};
         send_vector(vec);
         vec_index++;
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (board.pending() != 0)
         board.flag_mismatch($sformatf("%0d results never arrived", board.pending()));

      $display("Sent %0d vectors (%0d elements) under three idle phases; %0d results checked.",
         vectors_sent, items_sent, board.results_seen);
      $display("Mismatches: %0d", board.mismatch_count);
      if (board.mismatch_count == 0) begin
         $display("l2_vector_normalizer_core test passed");
      end else begin
         $display("l2_vector_normalizer_core test failed");
      end
      $finish;
   end

endmodule
